### src/dsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_pkg: docking steering controller shared types and constants
// Fixed-point widths, angle constants, CORDIC arctangent table, register map.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 24;             // position fields
  localparam int ANG_W     = 19;             // yaw / heading error fields
  localparam int CFG_W     = 23;             // widest register
  localparam int DIFF_W    = POS_W + 1;      // coordinate difference
  localparam int SQ_W      = 2 * DIFF_W;     // sum of squares
  localparam int ROOT_W    = DIFF_W;         // distance
  localparam int Z_W       = 35;             // CORDIC angle, 30 fraction bits
  localparam int Q30_SH    = 30 - FRAC_BITS;
  localparam int BEAR_W    = 20;             // bearing at FRAC_BITS
  localparam int QUOT_W    = 23;             // speed quotient
  localparam int NUM_W     = ROOT_W + FRAC_BITS;
  localparam int DEN_W     = FRAC_BITS + 1;
  localparam int TURN_W    = 24;

  localparam logic signed [Z_W-1:0]    PI_Q30     = 35'sd3373259426;
  localparam logic signed [BEAR_W-1:0] PI_FIX     = 20'sd205887;
  localparam logic signed [BEAR_W-1:0] TWO_PI_FIX = 20'sd411774;
  localparam logic [17:0]              FIVE_DEG   = 18'd5719;
  localparam logic [DEN_W-1:0]         ONE_FIX    = 17'd65536;

  typedef enum logic [2:0] {
    REG_TURN_GAIN     = 3'd0,
    REG_APPROACH_GAIN = 3'd1,
    REG_NEAR_DIST     = 3'd2,
    REG_FAR_DIST      = 3'd3,
    REG_MAX_SPEED     = 3'd4,
    REG_MAX_TURN      = 3'd5,
    REG_DONE_DIST     = 3'd6,
    REG_UNDER_DIST    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SPD_CENTER = 2'd0,
    SPD_ZERO   = 2'd1,
    SPD_MAX    = 2'd2,
    SPD_QUOT   = 2'd3
  } speed_sel_t;

  // results waiting on the speed divider
  typedef struct packed {
    logic signed [TURN_W-1:0] turn;
    logic signed [ANG_W-1:0]  err;
    logic                     docked;
    logic                     under;
    logic                     fault;
    speed_sel_t               sel;
    logic [ROOT_W-1:0]        d_center;
  } side_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:  a = 35'sd843314857;
      1:  a = 35'sd497837829;
      2:  a = 35'sd263043837;
      3:  a = 35'sd133525159;
      4:  a = 35'sd67021687;
      5:  a = 35'sd33543516;
      6:  a = 35'sd16775851;
      7:  a = 35'sd8388437;
      8:  a = 35'sd4194283;
      9:  a = 35'sd2097149;
      10: a = 35'sd1048576;
      11: a = 35'sd524288;
      12: a = 35'sd262144;
      13: a = 35'sd131072;
      14: a = 35'sd65536;
      15: a = 35'sd32768;
      16: a = 35'sd16384;
      17: a = 35'sd8192;
      18: a = 35'sd4096;
      19: a = 35'sd2048;
      20: a = 35'sd1024;
      21: a = 35'sd512;
      22: a = 35'sd256;
      23: a = 35'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### src/dsc_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_delay: fixed-depth shift line
// Carries side data alongside the arithmetic cell chains.
// ----------------------------------------------------------------------------
module dsc_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] line [0:DEPTH-1];

  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int k = 1; k < DEPTH; k++) begin
      line[k] <= line[k-1];
    end
  end

  assign q = line[DEPTH-1];
endmodule
`default_nettype wire

### src/dsc_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_sqrt_cell: one root bit of a restoring integer square root
// Decides root bit J and passes remainder and partial root on.
// ----------------------------------------------------------------------------
module dsc_sqrt_cell #(
  parameter int J = 0
) (
  input  wire logic                      clk,
  input  wire logic [dsc_pkg::SQ_W-1:0]   rem_in,
  input  wire logic [dsc_pkg::ROOT_W-1:0] root_in,
  output logic      [dsc_pkg::SQ_W-1:0]   rem_out,
  output logic      [dsc_pkg::ROOT_W-1:0] root_out
);
  import dsc_pkg::*;

  localparam logic [SQ_W:0] BIT_SQ = (SQ_W+1)'(1) << (2 * J);

  logic [SQ_W:0] trial;

  // (root + 2^J)^2 - root^2 = root*2^(J+1) + 2^(2J)
  assign trial = ((SQ_W+1)'(root_in) << (J + 1)) + BIT_SQ;

  always_ff @(posedge clk) begin
    if ({1'b0, rem_in} >= trial) begin
      rem_out  <= SQ_W'({1'b0, rem_in} - trial);
      root_out <= root_in | (ROOT_W'(1) << J);
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in;
    end
  end
endmodule
`default_nettype wire

### src/dsc_cordic_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_cordic_cell: one vectoring micro-rotation
// Drives y toward zero and accumulates the rotated angle at Q.30.
// ----------------------------------------------------------------------------
module dsc_cordic_cell #(
  parameter int XW = 44,
  parameter int I  = 0
) (
  input  wire logic                           clk,
  input  wire logic signed [XW-1:0]           x_in,
  input  wire logic signed [XW-1:0]           y_in,
  input  wire logic signed [dsc_pkg::Z_W-1:0] z_in,
  input  wire logic                           zero_in,
  output logic signed      [XW-1:0]           x_out,
  output logic signed      [XW-1:0]           y_out,
  output logic signed      [dsc_pkg::Z_W-1:0] z_out,
  output logic                                zero_out
);
  import dsc_pkg::*;

  localparam logic signed [Z_W-1:0] ANG = atan_q30(I);

  logic signed [XW-1:0] xs, ys;

  assign xs = x_in >>> I;
  assign ys = y_in >>> I;

  always_ff @(posedge clk) begin
    zero_out <= zero_in;
    if (!y_in[XW-1]) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + ANG;
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - ANG;
    end
  end
endmodule
`default_nettype wire

### src/dsc_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_div_cell: one quotient bit of a restoring divider
// Subtracts den << K from the remainder when it fits.
// ----------------------------------------------------------------------------
module dsc_div_cell #(
  parameter int K = 0
) (
  input  wire logic                      clk,
  input  wire logic [dsc_pkg::NUM_W-1:0]  rem_in,
  input  wire logic [dsc_pkg::DEN_W-1:0]  den_in,
  input  wire logic [dsc_pkg::QUOT_W-1:0] quot_in,
  output logic      [dsc_pkg::NUM_W-1:0]  rem_out,
  output logic      [dsc_pkg::DEN_W-1:0]  den_out,
  output logic      [dsc_pkg::QUOT_W-1:0] quot_out
);
  import dsc_pkg::*;

  logic [NUM_W-1:0] trial;

  assign trial = NUM_W'(den_in) << K;

  always_ff @(posedge clk) begin
    den_out <= den_in;
    if (rem_in >= trial) begin
      rem_out  <= rem_in - trial;
      quot_out <= quot_in | (QUOT_W'(1) << K);
    end else begin
      rem_out  <= rem_in;
      quot_out <= quot_in;
    end
  end
endmodule
`default_nettype wire

### src/docking_steering_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// docking_steering_controller: pose set in, steering command out
// Fully pipelined: one item accepted every cycle outside reset.
// ----------------------------------------------------------------------------
// An item is taken on every clock with start high while busy is low; busy is
// only high during reset. Each result appears on the output ports for one
// cycle with done high; the receiver cannot stall and there is no queue, so
// results leave in order at the rate items came in. The latency is set by
// four chains of registered cells: two 25-cell integer square roots, one per
// distance, a CORDIC_STAGES-cell atan2 running beside them, and a 23-cell
// restoring divider for the far-range speed.
// Configuration registers may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module docking_steering_controller #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           cfg_write,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [dsc_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic signed [dsc_pkg::POS_W-1:0] platform_x,
  input  wire logic signed [dsc_pkg::POS_W-1:0] platform_y,
  input  wire logic signed [dsc_pkg::ANG_W-1:0] platform_yaw,
  input  wire logic signed [dsc_pkg::POS_W-1:0] robot_x,
  input  wire logic signed [dsc_pkg::POS_W-1:0] robot_y,
  input  wire logic signed [dsc_pkg::ANG_W-1:0] robot_yaw,
  input  wire logic signed [dsc_pkg::POS_W-1:0] chassis_x,
  input  wire logic signed [dsc_pkg::POS_W-1:0] chassis_y,
  output logic                                done,
  output logic signed [dsc_pkg::TURN_W-1:0]   turn_rate,
  output logic        [22:0]                  forward_speed,
  output logic signed [dsc_pkg::ANG_W-1:0]    heading_error,
  output logic                                docked,
  output logic                                below_platform,
  output logic                                turn_fault
);
  import dsc_pkg::*;

  // x/y carry CORDIC_STAGES guard bits plus headroom for the CORDIC gain
  localparam int XW         = DIFF_W + CORDIC_STAGES + 3;
  localparam int SQRT_DONE  = 3 + ROOT_W;                 // distances ready
  localparam int BEAR_DLY   = SQRT_DONE - (3 + CORDIC_STAGES);
  localparam int LAT        = SQRT_DONE + 6 + QUOT_W;
  localparam int TGT_W      = 27;
  localparam int ERR_W      = TGT_W + 1;
  localparam int PROD_W     = 42;

  // ---------------------------------------------------------------- config
  logic [21:0]      turn_gain;
  logic [19:0]      approach_gain;
  logic [CFG_W-1:0] near_distance, far_distance, max_speed, max_turn_rate;
  logic [CFG_W-1:0] done_distance, under_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_gain      <= 22'd327680;
      approach_gain  <= 20'd131072;
      near_distance  <= 23'd7864;
      far_distance   <= 23'd32768;
      max_speed      <= 23'd32768;
      max_turn_rate  <= 23'd131072;
      done_distance  <= 23'd328;
      under_distance <= 23'd19661;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_TURN_GAIN:     turn_gain      <= cfg_data[21:0];
        REG_APPROACH_GAIN: approach_gain  <= cfg_data[19:0];
        REG_NEAR_DIST:     near_distance  <= cfg_data;
        REG_FAR_DIST:      far_distance   <= cfg_data;
        REG_MAX_SPEED:     max_speed      <= cfg_data;
        REG_MAX_TURN:      max_turn_rate  <= cfg_data;
        REG_DONE_DIST:     done_distance  <= cfg_data;
        REG_UNDER_DIST:    under_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------- valid line
  logic [LAT:1] vld;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-1:1], start};
    end
  end

  assign done = vld[LAT];

  // --------------------------------------------- stage 1: differences
  logic signed [DIFF_W-1:0] dxw, dyw, dxc, dyc;
  logic signed [ANG_W-1:0]  pyaw1, ryaw1;

  always_ff @(posedge clk) begin
    dxw   <= {platform_x[POS_W-1], platform_x} - {robot_x[POS_W-1], robot_x};
    dyw   <= {platform_y[POS_W-1], platform_y} - {robot_y[POS_W-1], robot_y};
    dxc   <= {platform_x[POS_W-1], platform_x} - {chassis_x[POS_W-1], chassis_x};
    dyc   <= {platform_y[POS_W-1], platform_y} - {chassis_y[POS_W-1], chassis_y};
    pyaw1 <= platform_yaw;
    ryaw1 <= robot_yaw;
  end

  // ------------------------------ stage 2: squares, CORDIC pre-rotation
  logic signed [SQ_W-1:0] sq_wx_c, sq_wy_c, sq_cx_c, sq_cy_c;
  logic [SQ_W-1:0]        sq_wx, sq_wy, sq_cx, sq_cy;

  assign sq_wx_c = dxw * dxw;
  assign sq_wy_c = dyw * dyw;
  assign sq_cx_c = dxc * dxc;
  assign sq_cy_c = dyc * dyc;

  logic signed [XW-1:0]  cx [0:CORDIC_STAGES];
  logic signed [XW-1:0]  cy [0:CORDIC_STAGES];
  logic signed [Z_W-1:0] cz [0:CORDIC_STAGES];
  logic                  cz0 [0:CORDIC_STAGES];
  logic signed [XW-1:0]  x_ext, y_ext;

  assign x_ext = XW'(dxw) <<< CORDIC_STAGES;
  assign y_ext = XW'(dyw) <<< CORDIC_STAGES;

  always_ff @(posedge clk) begin
    sq_wx <= sq_wx_c;
    sq_wy <= sq_wy_c;
    sq_cx <= sq_cx_c;
    sq_cy <= sq_cy_c;
    cz0[0] <= (dxw == '0) && (dyw == '0);
    // left half plane: rotate by pi so the cells see x >= 0
    if (dxw[DIFF_W-1]) begin
      cx[0] <= -x_ext;
      cy[0] <= -y_ext;
      cz[0] <= dyw[DIFF_W-1] ? -PI_Q30 : PI_Q30;
    end else begin
      cx[0] <= x_ext;
      cy[0] <= y_ext;
      cz[0] <= '0;
    end
  end

  // ------------------------------------------------- stage 3: sums
  logic [SQ_W-1:0]   rem_w [0:ROOT_W];
  logic [SQ_W-1:0]   rem_c [0:ROOT_W];
  logic [ROOT_W-1:0] root_w [0:ROOT_W];
  logic [ROOT_W-1:0] root_c [0:ROOT_W];

  always_ff @(posedge clk) begin
    rem_w[0] <= sq_wx + sq_wy;
    rem_c[0] <= sq_cx + sq_cy;
  end

  assign root_w[0] = '0;
  assign root_c[0] = '0;

  // square root rows, most significant root bit first
  for (genvar c = 0; c < ROOT_W; c++) begin : g_sqrt
    dsc_sqrt_cell #(.J(ROOT_W - 1 - c)) u_wheel (
      .clk(clk), .rem_in(rem_w[c]), .root_in(root_w[c]),
      .rem_out(rem_w[c+1]), .root_out(root_w[c+1])
    );
    dsc_sqrt_cell #(.J(ROOT_W - 1 - c)) u_center (
      .clk(clk), .rem_in(rem_c[c]), .root_in(root_c[c]),
      .rem_out(rem_c[c+1]), .root_out(root_c[c+1])
    );
  end

  // CORDIC row
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    dsc_cordic_cell #(.XW(XW), .I(i)) u_cell (
      .clk(clk),
      .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]), .zero_in(cz0[i]),
      .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1]), .zero_out(cz0[i+1])
    );
  end

  // bearing rounded to nearest at FRAC_BITS; coincident points give zero
  logic signed [Z_W-1:0]    z_rnd;
  logic signed [BEAR_W-1:0] bear, bear_d;

  assign z_rnd = cz[CORDIC_STAGES] + Z_W'(1 <<< (Q30_SH - 1));

  always_ff @(posedge clk) begin
    bear <= cz0[CORDIC_STAGES] ? '0 : BEAR_W'(z_rnd >>> Q30_SH);
  end

  dsc_delay #(.W(BEAR_W), .DEPTH(BEAR_DLY)) u_bear_dly (
    .clk(clk), .d(bear), .q(bear_d)
  );

  logic [2*ANG_W-1:0]      yaw_d;
  logic signed [ANG_W-1:0] pyaw_d, ryaw_d;

  dsc_delay #(.W(2 * ANG_W), .DEPTH(SQRT_DONE - 1)) u_yaw_dly (
    .clk(clk), .d({pyaw1, ryaw1}), .q(yaw_d)
  );

  assign pyaw_d = yaw_d[2*ANG_W-1:ANG_W];
  assign ryaw_d = yaw_d[ANG_W-1:0];

  // ------------------------------------- post stage A: bearing * gain
  logic signed [BEAR_W:0]   dir;
  logic signed [PROD_W-1:0] prod_a_c;
  logic signed [PROD_W-1:0] prod_a;
  logic                     near_a;
  logic [ROOT_W-1:0]        dw_a, dc_a;
  logic signed [ANG_W-1:0]  pyaw_a, ryaw_a;

  assign dir      = (BEAR_W+1)'(bear_d) - (BEAR_W+1)'(pyaw_d);
  assign prod_a_c = dir * $signed({1'b0, approach_gain});

  always_ff @(posedge clk) begin
    prod_a <= prod_a_c;
    near_a <= root_w[ROOT_W] > ROOT_W'(near_distance);
    dw_a   <= root_w[ROOT_W];
    dc_a   <= root_c[ROOT_W];
    pyaw_a <= pyaw_d;
    ryaw_a <= ryaw_d;
  end

  // ------------------------------- post stage B: target, yaw wrapping
  logic signed [TGT_W-1:0]  t0, t1, t2, tgt_b;
  logic signed [BEAR_W-1:0] r0, r1, r2, ryaw_b;
  logic [ROOT_W-1:0]        dw_b, dc_b;

  always_comb begin
    t0 = near_a ? TGT_W'(pyaw_a) + TGT_W'(prod_a >>> FRAC_BITS) : TGT_W'(pyaw_a);
    t1 = (t0 < -PI_FIX) ? t0 + TGT_W'(TWO_PI_FIX) : t0;
    t2 = (t1 > PI_FIX) ? t1 - TGT_W'(TWO_PI_FIX) : t1;
    r0 = BEAR_W'(ryaw_a);
    r1 = (r0 > PI_FIX) ? r0 - TWO_PI_FIX : r0;
    r2 = (r1 < -PI_FIX) ? r1 + TWO_PI_FIX : r1;
  end

  always_ff @(posedge clk) begin
    tgt_b  <= t2;
    ryaw_b <= r2;
    dw_b   <= dw_a;
    dc_b   <= dc_a;
  end

  // ---------------------------------- post stage C: heading error
  logic signed [ERR_W-1:0] e0, e1, e2, e3;
  logic signed [ANG_W-1:0] err_c;
  logic [17:0]             aerr_c;
  logic [ROOT_W-1:0]       dw_c, dc_c;

  always_comb begin
    e0 = ERR_W'(tgt_b) - ERR_W'(ryaw_b);
    e1 = (e0 > PI_FIX) ? e0 - ERR_W'(TWO_PI_FIX) : e0;
    e2 = (e1 < -PI_FIX) ? e1 + ERR_W'(TWO_PI_FIX) : e1;
    if (e2 > PI_FIX) begin
      e3 = ERR_W'(PI_FIX);
    end else if (e2 < -PI_FIX) begin
      e3 = -ERR_W'(PI_FIX);
    end else begin
      e3 = e2;
    end
  end

  always_ff @(posedge clk) begin
    err_c  <= ANG_W'(e3);
    aerr_c <= e3[ERR_W-1] ? 18'(-e3) : 18'(e3);
    dw_c   <= dw_b;
    dc_c   <= dc_b;
  end

  // ----------------------- post stage D: turn product, speed setup, flags
  logic signed [PROD_W-1:0] prod_d_c, prod_d;
  logic [23:0]              a50;
  logic [DEN_W-1:0]         den_d;
  logic                     slow_d, far_d, under_d, fault_d, docked_d;
  logic signed [ANG_W-1:0]  err_d;
  logic [ROOT_W-1:0]        dw_d, dc_d;
  logic                     under_c;

  assign prod_d_c = err_c * $signed({1'b0, turn_gain});
  // 50 * |err| as shift-add
  assign a50      = (24'(aerr_c) << 5) + (24'(aerr_c) << 4) + (24'(aerr_c) << 1);
  assign under_c  = dw_c < ROOT_W'(under_distance);

  always_ff @(posedge clk) begin
    prod_d   <= prod_d_c;
    slow_d   <= a50 < 24'(ONE_FIX);
    den_d    <= DEN_W'(24'(ONE_FIX) - a50);
    far_d    <= dw_c > ROOT_W'(far_distance);
    under_d  <= under_c;
    fault_d  <= under_c && (aerr_c > FIVE_DEG);
    docked_d <= dc_c < ROOT_W'(done_distance);
    err_d    <= err_c;
    dw_d     <= dw_c;
    dc_d     <= dc_c;
  end

  // ------------------------ post stage E: turn clamp, divider entry
  localparam int TSH_W = PROD_W - FRAC_BITS;

  logic signed [TSH_W-1:0] tsh, tmax;
  logic [NUM_W-1:0]        num;
  logic                    num_big;
  side_t                   side_e, side_q;
  logic [$bits(side_t)-1:0] side_bits;

  logic [NUM_W-1:0]  drem [0:QUOT_W];
  logic [DEN_W-1:0]  dden [0:QUOT_W];
  logic [QUOT_W-1:0] dquo [0:QUOT_W];

  assign tsh     = TSH_W'(prod_d >>> FRAC_BITS);
  assign tmax    = TSH_W'({1'b0, max_turn_rate});
  assign num     = {dw_d, {FRAC_BITS{1'b0}}};
  // quotient would not fit QUOT_W bits: it lies above any max_speed
  assign num_big = num >= (NUM_W'(den_d) << QUOT_W);

  always_ff @(posedge clk) begin
    if (tsh > tmax) begin
      side_e.turn <= TURN_W'(tmax);
    end else if (tsh < -tmax) begin
      side_e.turn <= TURN_W'(-tmax);
    end else begin
      side_e.turn <= TURN_W'(tsh);
    end
    side_e.err      <= err_d;
    side_e.docked   <= docked_d;
    side_e.under    <= under_d;
    side_e.fault    <= fault_d;
    side_e.d_center <= dc_d;
    if (!far_d) begin
      side_e.sel <= SPD_CENTER;
    end else if (!slow_d) begin
      side_e.sel <= SPD_ZERO;
    end else if (num_big) begin
      side_e.sel <= SPD_MAX;
    end else begin
      side_e.sel <= SPD_QUOT;
    end
    drem[0] <= num;
    dden[0] <= den_d;
  end

  assign dquo[0] = '0;

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    dsc_div_cell #(.K(QUOT_W - 1 - k)) u_cell (
      .clk(clk),
      .rem_in(drem[k]), .den_in(dden[k]), .quot_in(dquo[k]),
      .rem_out(drem[k+1]), .den_out(dden[k+1]), .quot_out(dquo[k+1])
    );
  end

  dsc_delay #(.W($bits(side_t)), .DEPTH(QUOT_W)) u_side_dly (
    .clk(clk), .d(side_e), .q(side_bits)
  );

  assign side_q = side_t'(side_bits);

  // ------------------------------------------------- output register
  always_ff @(posedge clk) begin
    turn_rate      <= side_q.turn;
    heading_error  <= side_q.err;
    docked         <= side_q.docked;
    below_platform <= side_q.under;
    turn_fault     <= side_q.fault;
    case (side_q.sel)
      SPD_CENTER: forward_speed <= (side_q.d_center > ROOT_W'(max_speed)) ?
                                   max_speed : 23'(side_q.d_center);
      SPD_ZERO:   forward_speed <= '0;
      SPD_MAX:    forward_speed <= max_speed;
      SPD_QUOT:   forward_speed <= (dquo[QUOT_W] > max_speed) ?
                                   max_speed : dquo[QUOT_W];
      default:    forward_speed <= '0;
    endcase
  end

  // ------------------------------------------------------- assertions
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("result strobe missing at fixed latency");

  a_turn_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> (turn_rate <= $signed({1'b0, max_turn_rate})) &&
             (turn_rate >= -$signed({1'b0, max_turn_rate})))
    else $error("turn rate outside clamp");

  a_speed_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> forward_speed <= max_speed)
    else $error("forward speed above clamp");

  a_fault_under: assert property (@(posedge clk) disable iff (rst)
    (done && turn_fault) |-> below_platform)
    else $error("turn fault while not below platform");

endmodule
`default_nettype wire

### tb/sv/docking_steering_controller_tb.sv
// ----------------------------------------------------------------------------
// docking_steering_controller_tb: self-checking bench for the steering block
// Feeds pose sets through the command port with random gaps, predicts each
// steering command with a behavioral model of the pipeline and checks every
// strobed result in order, across several register settings.
// ----------------------------------------------------------------------------
module docking_steering_controller_tb;
  import dsc_pkg::*;

  typedef struct {
    logic signed [23:0] px, py;
    logic signed [18:0] pyaw;
    logic signed [23:0] rx, ry;
    logic signed [18:0] ryaw;
    logic signed [23:0] cx, cy;
  } pose_t;

  typedef struct {
    logic signed [23:0] turn;
    logic [22:0]        speed;
    logic signed [18:0] err;
    logic               docked;
    logic               under;
    logic               fault;
  } steer_t;

  localparam longint PI_Q16   = 205887;
  localparam longint FIVE_DEG_Q16 = 5719;
  localparam longint ONE_Q16  = 65536;
  localparam longint ATAN_TBL [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic signed [23:0] platform_x = '0, platform_y = '0;
  logic signed [18:0] platform_yaw = '0;
  logic signed [23:0] robot_x = '0, robot_y = '0;
  logic signed [18:0] robot_yaw = '0;
  logic signed [23:0] chassis_x = '0, chassis_y = '0;
  logic done;
  logic signed [23:0] turn_rate;
  logic [22:0] forward_speed;
  logic signed [18:0] heading_error;
  logic docked, below_platform, turn_fault;

  docking_steering_controller dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .platform_x(platform_x), .platform_y(platform_y), .platform_yaw(platform_yaw),
    .robot_x(robot_x), .robot_y(robot_y), .robot_yaw(robot_yaw),
    .chassis_x(chassis_x), .chassis_y(chassis_y),
    .done(done), .turn_rate(turn_rate), .forward_speed(forward_speed),
    .heading_error(heading_error), .docked(docked),
    .below_platform(below_platform), .turn_fault(turn_fault)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow copy of the register file, indexed by cfg_reg_t
  longint cfg_shadow [8];
  pose_t  pending_poses[$];      // items waiting for the driver
  steer_t expected_cmds[$];      // commands in flight through the pipeline
  bit     failed = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic longint isqrt_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint distance_q16(longint dx, longint dy);
    return isqrt_floor(longint'(dx * dx) + longint'(dy * dy));
  endfunction

  // CORDIC vectoring atan2, angle kept at 30 fraction bits
  function automatic longint bearing_q16(longint dx, longint dy);
    longint x, y, z, xs, ys;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 65536;
    y = dy * 65536;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_TBL[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TBL[i];
      end
    end
    return (z + (64'sd1 << 13)) >>> 14;
  endfunction

  function automatic steer_t predict_steer(pose_t p);
    steer_t c;
    longint d_wheel, d_center, target, ryaw, err, aerr, turn, speed;
    d_wheel  = distance_q16(longint'(p.px) - p.rx, longint'(p.py) - p.ry);
    d_center = distance_q16(longint'(p.px) - p.cx, longint'(p.py) - p.cy);
    if (d_wheel > cfg_shadow[REG_NEAR_DIST])
      target = p.pyaw + (((bearing_q16(longint'(p.px) - p.rx, longint'(p.py) - p.ry)
               - p.pyaw) * cfg_shadow[REG_APPROACH_GAIN]) >>> 16);
    else
      target = p.pyaw;
    if (target < -PI_Q16) target += 2 * PI_Q16;
    if (target > PI_Q16) target -= 2 * PI_Q16;
    ryaw = p.ryaw;
    if (ryaw > PI_Q16) ryaw -= 2 * PI_Q16;
    if (ryaw < -PI_Q16) ryaw += 2 * PI_Q16;
    err = target - ryaw;
    if (err > PI_Q16) err -= 2 * PI_Q16;
    if (err < -PI_Q16) err += 2 * PI_Q16;
    if (err > PI_Q16) err = PI_Q16;
    if (err < -PI_Q16) err = -PI_Q16;
    aerr = (err < 0) ? -err : err;
    turn = (err * cfg_shadow[REG_TURN_GAIN]) >>> 16;
    if (turn > cfg_shadow[REG_MAX_TURN]) turn = cfg_shadow[REG_MAX_TURN];
    if (turn < -cfg_shadow[REG_MAX_TURN]) turn = -cfg_shadow[REG_MAX_TURN];
    if (d_wheel > cfg_shadow[REG_FAR_DIST])
      speed = (50 * aerr < ONE_Q16) ? (d_wheel * ONE_Q16) / (ONE_Q16 - 50 * aerr) : 0;
    else
      speed = d_center;
    if (speed > cfg_shadow[REG_MAX_SPEED]) speed = cfg_shadow[REG_MAX_SPEED];
    c.turn   = turn[23:0];
    c.speed  = speed[22:0];
    c.err    = err[18:0];
    c.docked = d_center < cfg_shadow[REG_DONE_DIST];
    c.under  = d_wheel < cfg_shadow[REG_UNDER_DIST];
    c.fault  = c.under && (aerr > FIVE_DEG_Q16);
    return c;
  endfunction

  // ------------------------------------------------------------------- driver
  int  gap_left = 0;
  bit  no_gaps = 1'b0;   // stretches of back-to-back items

  always @(posedge clk) begin
    pose_t nxt;
    bit    drive_next;
    if (start && !busy)
      expected_cmds.push_back(predict_steer('{platform_x, platform_y, platform_yaw,
          robot_x, robot_y, robot_yaw, chassis_x, chassis_y}));
    drive_next = 1'b0;
    if (start && busy) begin
      drive_next = 1'b1;            // hold the item until taken
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
    end else if (pending_poses.size() > 0) begin
      nxt = pending_poses.pop_front();
      platform_x <= nxt.px;  platform_y <= nxt.py;  platform_yaw <= nxt.pyaw;
      robot_x <= nxt.rx;     robot_y <= nxt.ry;     robot_yaw <= nxt.ryaw;
      chassis_x <= nxt.cx;   chassis_y <= nxt.cy;
      drive_next = 1'b1;
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      gap_left <= no_gaps ? 0 : $urandom_range(0, 7);
    end
    start <= drive_next;
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    steer_t exp_cmd;
    if (!rst && done) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t unexpected result: turn=%0d speed=%0d err=%0d", $time,
                 turn_rate, forward_speed, heading_error);
        failed = 1'b1;
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (turn_rate !== exp_cmd.turn) begin
          $display("%0t turn_rate exp %0d got %0d", $time, exp_cmd.turn, turn_rate);
          failed = 1'b1;
        end
        if (forward_speed !== exp_cmd.speed) begin
          $display("%0t forward_speed exp %0d got %0d", $time, exp_cmd.speed,
                   forward_speed);
          failed = 1'b1;
        end
        if (heading_error !== exp_cmd.err) begin
          $display("%0t heading_error exp %0d got %0d", $time, exp_cmd.err,
                   heading_error);
          failed = 1'b1;
        end
        if (docked !== exp_cmd.docked) begin
          $display("%0t docked exp %0b got %0b", $time, exp_cmd.docked, docked);
          failed = 1'b1;
        end
        if (below_platform !== exp_cmd.under) begin
          $display("%0t below_platform exp %0b got %0b", $time, exp_cmd.under,
                   below_platform);
          failed = 1'b1;
        end
        if (turn_fault !== exp_cmd.fault) begin
          $display("%0t turn_fault exp %0b got %0b", $time, exp_cmd.fault, turn_fault);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [23:0] clip24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  function automatic longint offset(int r);
    return longint'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic logic signed [18:0] yaw_in_range();
    return 19'(offset(205887));
  endfunction

  // kinds: 0-2 anything, 3-5 robot near the platform, 6-8 heading roughly
  // aligned so the far-range divider sees small errors, 9 corner values
  function automatic pose_t make_pose(int kind);
    pose_t p;
    steer_t c;
    longint bx, by;
    bx = offset(4000000);
    by = offset(4000000);
    p.px = 24'($urandom); p.py = 24'($urandom);
    p.rx = 24'($urandom); p.ry = 24'($urandom);
    p.cx = 24'($urandom); p.cy = 24'($urandom);
    p.pyaw = ($urandom_range(0, 3) == 0) ? 19'($urandom) : yaw_in_range();
    p.ryaw = ($urandom_range(0, 3) == 0) ? 19'($urandom) : yaw_in_range();
    if (kind >= 3 && kind <= 5) begin
      p.px = 24'(bx); p.py = 24'(by);
      p.rx = clip24(bx + offset($urandom_range(0, 1) ? 40000 : 400));
      p.ry = clip24(by + offset($urandom_range(0, 1) ? 40000 : 400));
      p.cx = clip24(bx + offset($urandom_range(0, 1) ? 20000 : 300));
      p.cy = clip24(by + offset($urandom_range(0, 1) ? 20000 : 300));
      if ($urandom_range(0, 3) == 0) p.ryaw = p.pyaw + 19'(offset(6000));
    end else if (kind >= 6 && kind <= 8) begin
      p.px = 24'(bx); p.py = 24'(by);
      p.rx = clip24(bx + offset(300000));
      p.ry = clip24(by + offset(300000));
      p.ryaw = '0;
      c = predict_steer(p);
      p.ryaw = 19'(longint'(c.err) + offset(1500));
    end else if (kind == 9) begin
      p.px = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      p.py = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      p.rx = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      p.ry = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      p.pyaw = $urandom_range(0, 1) ? 19'sd205887 : -19'sd205887;
      p.ryaw = $urandom_range(0, 1) ? 19'sh3ffff : 19'sh40000;
    end
    return p;
  endfunction

  task automatic write_regs(longint v [8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= v[i][CFG_W-1:0];
      cfg_shadow[i] = v[i];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // sender holds off until every command is back, then the pipe drains
  task automatic drain();
    while (pending_poses.size() != 0 || start || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_poses.push_back(make_pose($urandom_range(0, 9)));
  endtask

  initial begin
    longint regs [8];
    pose_t  p;
    cfg_shadow = '{327680, 131072, 7864, 32768, 32768, 131072, 328, 19661};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, coincident points, near/docked/under, yaw wrap
    p = '{'0, '0, '0, '0, '0, '0, '0, '0};
    pending_poses.push_back(p);                                   // all coincide
    p = '{24'sh7fffff, 24'sh7fffff, 19'sd205887, 24'sh800000, 24'sh800000,
          -19'sd205887, 24'sh800000, 24'sh800000};
    pending_poses.push_back(p);
    p = '{24'sh800000, 24'sh7fffff, -19'sd205887, 24'sh7fffff, 24'sh800000,
          19'sd205887, 24'sh7fffff, 24'sh800000};
    pending_poses.push_back(p);
    p = '{24'sd1000, 24'sd1000, 19'sd1000, 24'sd1000, 24'sd1000, 19'sh3ffff,
          24'sd1100, 24'sd1000};                                   // docked, wild yaw
    pending_poses.push_back(p);
    p = '{24'sd0, 24'sd0, 19'sd0, 24'sd5000, 24'sd0, 19'sh40000, 24'sd0, 24'sd0};
    pending_poses.push_back(p);                                   // under, fault
    p = '{24'sd0, 24'sd0, 19'sd100, 24'sd0, 24'sd0, 19'sd100, 24'sd9000, 24'sd0};
    pending_poses.push_back(p);                                   // under, no fault
    p = '{24'sd0, 24'sd0, 19'sd0, -24'sd200000, 24'sd0, 19'sd0, 24'sd0, 24'sd0};
    pending_poses.push_back(p);                                   // far, aligned
    p = '{24'sd0, 24'sd0, 19'sd0, 24'sd200000, 24'sd0, 19'sd0, 24'sd0, 24'sd0};
    pending_poses.push_back(p);                                   // far, bearing pi
    p = '{24'sd0, 24'sd0, 19'sd0, 24'sd0, 24'sd20000, 19'sd0, 24'sd0, 24'sd0};
    pending_poses.push_back(p);                                   // between near and far
    for (int i = 0; i < 16; i++) pending_poses.push_back(make_pose(i % 10));
    queue_random(300);
    drain();

    regs = '{2097152, 524288, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607};
    write_regs(regs);
    queue_random(250);
    drain();

    regs = '{0, 0, 0, 0, 0, 0, 0, 0};
    write_regs(regs);
    queue_random(250);
    drain();

    regs = '{65536, 65536, 20000, 100000, 8388607, 8388607, 500, 30000};
    write_regs(regs);
    queue_random(300);
    drain();

    for (int i = 0; i < 8; i++) regs[i] = $urandom_range(0, 800000);
    regs[0] = $urandom_range(0, 2097152);
    regs[1] = $urandom_range(0, 524288);
    write_regs(regs);
    queue_random(250);
    drain();

    if (!failed)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
